// ===== rtl/hed_pkg.sv =====
// hed_pkg: shared types, character codes and helper functions of the HTML entity decoder.
// Used by hed_ctrl, hed_datapath, html_entity_decoder_unit and hed_checker. No dependencies.
`timescale 1ns / 1ps

package hed_pkg;

	localparam int ENTITY_WINDOW_DEF = 10;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	localparam logic [20:0] CODE_LIMIT = 21'h110000;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} hed_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} hed_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MATCH,
		S_PARSE,
		S_UTF,
		S_VAMP,
		S_VBYTES,
		S_VSEMI,
		S_RAMP,
		S_RSTEP
	} hed_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_APPEND,
		OP_PARSE_INIT,
		OP_PARSE_STEP,
		OP_IDX_CLR,
		OP_IDX_INC,
		OP_RESCAN_INIT,
		OP_RESCAN_STEP
	} hed_op_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_IN,
		EM_AMP,
		EM_SEMI,
		EM_BUF,
		EM_NAME,
		EM_UTF,
		EM_CUR
	} hed_emit_t;

	typedef struct packed {
		hed_op_t   op;
		logic      take;
		logic      store;
		logic      look;
		hed_emit_t emit;
		logic      last;
		logic      done;
	} hed_cmd_t;

	typedef struct packed {
		logic can_emit;
		logic in_amp;
		logic in_semi;
		logic in_eot;
		logic eot;
		logic cnt_zero;
		logic cnt_fill;
		logic name_hit;
		logic num_start;
		logic parse_end;
		logic digit_bad;
		logic code_ok;
		logic utf_last;
		logic buf_last;
		logic buf0_amp;
		logic cur_amp;
		logic look_amp;
		logic idx_end;
	} hed_stat_t;

	// {valid, value}
	function automatic logic [4:0] digit_value(input logic [7:0] c, input logic hex);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (hex && c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (hex && c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// UTF-8 length minus one
	function automatic logic [1:0] utf8_lm1(input logic [20:0] code);
		logic [1:0] r;
		if (code < 21'h80) begin
			r = 2'd0;
		end else if (code < 21'h800) begin
			r = 2'd1;
		end else if (code < 21'h10000) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] code, input logic [1:0] lm1,
		input logic [1:0] pos);
		logic [7:0] r;
		r = {2'b10, code[5:0]};
		unique case (lm1)
			2'd0: r = code[7:0];
			2'd1: begin
				if (pos == 2'd0) r = {3'b110, code[10:6]};
			end
			2'd2: begin
				if (pos == 2'd0) r = {4'b1110, code[15:12]};
				else if (pos == 2'd1) r = {2'b10, code[11:6]};
			end
			2'd3: begin
				if (pos == 2'd0) r = {5'b11110, code[20:18]};
				else if (pos == 2'd1) r = {2'b10, code[17:12]};
				else if (pos == 2'd2) r = {2'b10, code[11:6]};
			end
			default: r = code[7:0];
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/hed_datapath.sv =====
// hed_datapath: entity byte buffer, counters, numeric accumulator, name match and output register.
// Depends on hed_pkg; driven by hed_ctrl through hed_cmd_t, reports through hed_stat_t.
`timescale 1ns / 1ps

module hed_datapath #(
	parameter int ENTITY_WINDOW = hed_pkg::ENTITY_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hed_pkg::hed_in_t   in_data,
	input  hed_pkg::hed_cmd_t  cmd,
	output hed_pkg::hed_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output hed_pkg::hed_out_t  out_data
);

	localparam int CNT_W = $clog2(ENTITY_WINDOW + 1);
	localparam int IDX_W = $clog2(ENTITY_WINDOW);

	logic [7:0]       buf_q [ENTITY_WINDOW];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] look_idx;
	logic             look_ok;
	logic [IDX_W-1:0] rd_idx;
	logic [7:0]       rd_byte;
	logic [7:0]       cur_q;
	logic             eot_q;
	logic             hex_q;
	logic [20:0]      code_q;
	logic [20:0]      code_nx;
	logic [24:0]      code_sum;
	logic [4:0]       dig;
	logic [1:0]       utf_lm1;
	logic             name_hit;
	logic [7:0]       name_byte;
	logic [7:0]       emit_byte;
	logic             out_valid_q;
	hed_pkg::hed_out_t out_q;

	assign look_idx = idx_q + CNT_W'(1);
	assign look_ok  = look_idx < CNT_W'(ENTITY_WINDOW);
	assign rd_idx   = cmd.look ? (look_ok ? look_idx[IDX_W-1:0] : '0) : idx_q[IDX_W-1:0];
	assign rd_byte  = buf_q[rd_idx];

	assign dig      = hed_pkg::digit_value(rd_byte, hex_q);
	assign code_sum = hex_q ? (25'({code_q, 4'h0}) + 25'(dig[3:0]))
		: (25'({code_q, 3'b000}) + 25'({code_q, 1'b0}) + 25'(dig[3:0]));
	assign code_nx  = (code_sum > 25'(hed_pkg::CODE_LIMIT)) ? hed_pkg::CODE_LIMIT
		: code_sum[20:0];
	assign utf_lm1  = hed_pkg::utf8_lm1(code_q);

	always_comb begin
		name_hit  = 1'b1;
		name_byte = hed_pkg::CH_AMP;
		priority if (cnt_q == CNT_W'(3) && {buf_q[0], buf_q[1], buf_q[2]} == "amp") begin
			name_byte = hed_pkg::CH_AMP;
		end else if (cnt_q == CNT_W'(2) && {buf_q[0], buf_q[1]} == "lt") begin
			name_byte = hed_pkg::CH_LT;
		end else if (cnt_q == CNT_W'(2) && {buf_q[0], buf_q[1]} == "gt") begin
			name_byte = hed_pkg::CH_GT;
		end else if (cnt_q == CNT_W'(4)
			&& {buf_q[0], buf_q[1], buf_q[2], buf_q[3]} == "quot") begin
			name_byte = hed_pkg::CH_QUOT;
		end else if (cnt_q == CNT_W'(4)
			&& {buf_q[0], buf_q[1], buf_q[2], buf_q[3]} == "apos") begin
			name_byte = hed_pkg::CH_APOS;
		end else if (cnt_q == CNT_W'(4)
			&& {buf_q[0], buf_q[1], buf_q[2], buf_q[3]} == "nbsp") begin
			name_byte = hed_pkg::CH_SPACE;
		end else begin
			name_hit = 1'b0;
		end
	end

	always_comb begin
		unique case (cmd.emit)
			hed_pkg::EM_IN:   emit_byte = in_data.in_byte;
			hed_pkg::EM_AMP:  emit_byte = hed_pkg::CH_AMP;
			hed_pkg::EM_SEMI: emit_byte = hed_pkg::CH_SEMI;
			hed_pkg::EM_BUF:  emit_byte = rd_byte;
			hed_pkg::EM_NAME: emit_byte = name_byte;
			hed_pkg::EM_UTF:  emit_byte = hed_pkg::utf8_byte(code_q, utf_lm1, idx_q[1:0]);
			hed_pkg::EM_CUR:  emit_byte = cur_q;
			default:          emit_byte = in_data.in_byte;
		endcase
	end

	always_comb begin
		stat.can_emit  = !out_valid_q || out_ready;
		stat.in_amp    = in_data.in_byte == hed_pkg::CH_AMP;
		stat.in_semi   = in_data.in_byte == hed_pkg::CH_SEMI;
		stat.in_eot    = in_data.end_of_text;
		stat.eot       = eot_q;
		stat.cnt_zero  = cnt_q == '0;
		stat.cnt_fill  = cnt_q == CNT_W'(ENTITY_WINDOW - 1);
		stat.name_hit  = name_hit;
		stat.num_start = cnt_q >= CNT_W'(2) && buf_q[0] == hed_pkg::CH_HASH;
		stat.parse_end = idx_q == cnt_q;
		stat.digit_bad = !dig[4];
		stat.code_ok   = code_q != '0 && code_q < hed_pkg::CODE_LIMIT;
		stat.utf_last  = idx_q == CNT_W'(utf_lm1);
		stat.buf_last  = idx_q == cnt_q - CNT_W'(1);
		stat.buf0_amp  = buf_q[0] == hed_pkg::CH_AMP;
		stat.cur_amp   = cur_q == hed_pkg::CH_AMP;
		stat.look_amp  = look_ok && rd_byte == hed_pkg::CH_AMP;
		stat.idx_end   = idx_q == CNT_W'(ENTITY_WINDOW - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				hed_pkg::OP_CLEAR:       cnt_q <= '0;
				hed_pkg::OP_RESCAN_INIT: cnt_q <= '0;
				hed_pkg::OP_APPEND:      cnt_q <= cnt_q + CNT_W'(1);
				hed_pkg::OP_RESCAN_STEP: begin
					if (cmd.store) cnt_q <= cnt_q + CNT_W'(1);
				end
				default: ;
			endcase
			unique case (cmd.op)
				hed_pkg::OP_PARSE_INIT: begin
					idx_q <= (buf_q[1] == hed_pkg::CH_LX || buf_q[1] == hed_pkg::CH_UX)
						? CNT_W'(2) : CNT_W'(1);
				end
				hed_pkg::OP_PARSE_STEP, hed_pkg::OP_IDX_INC, hed_pkg::OP_RESCAN_STEP: begin
					idx_q <= idx_q + CNT_W'(1);
				end
				hed_pkg::OP_IDX_CLR, hed_pkg::OP_RESCAN_INIT: idx_q <= '0;
				default: ;
			endcase
			if (cmd.emit != hed_pkg::EM_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) eot_q <= in_data.end_of_text;
		unique case (cmd.op)
			hed_pkg::OP_APPEND: buf_q[cnt_q[IDX_W-1:0]] <= in_data.in_byte;
			hed_pkg::OP_PARSE_INIT: begin
				hex_q  <= buf_q[1] == hed_pkg::CH_LX || buf_q[1] == hed_pkg::CH_UX;
				code_q <= '0;
			end
			hed_pkg::OP_PARSE_STEP:  code_q <= code_nx;
			hed_pkg::OP_RESCAN_INIT: cur_q <= buf_q[0];
			hed_pkg::OP_RESCAN_STEP: begin
				if (cmd.store) buf_q[cnt_q[IDX_W-1:0]] <= cur_q;
				cur_q <= rd_byte;
			end
			default: ;
		endcase
		if (cmd.emit != hed_pkg::EM_NONE) begin
			out_q.out_byte  <= emit_byte;
			out_q.run_last  <= cmd.last;
			out_q.text_done <= cmd.done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/hed_ctrl.sv =====
// hed_ctrl: state machine of the HTML entity decoder; sequences resolve, verbatim and rescan.
// Depends on hed_pkg; commands hed_datapath through hed_cmd_t.
`timescale 1ns / 1ps

module hed_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hed_pkg::hed_stat_t stat,
	output hed_pkg::hed_cmd_t  cmd
);

	hed_pkg::hed_state_t state_q, state_d;
	logic open_q, open_d;
	logic semi_q, semi_d;
	logic emit_need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hed_pkg::S_IDLE;
			open_q  <= 1'b0;
			semi_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			open_q  <= open_d;
			semi_q  <= semi_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		open_d    = open_q;
		semi_d    = semi_q;
		cmd.op    = hed_pkg::OP_NONE;
		cmd.take  = 1'b0;
		cmd.store = 1'b0;
		cmd.look  = 1'b0;
		cmd.emit  = hed_pkg::EM_NONE;
		cmd.last  = 1'b0;
		cmd.done  = 1'b0;
		in_ready  = 1'b0;
		emit_need = !open_q && !stat.cur_amp;

		unique case (state_q)
			hed_pkg::S_IDLE: begin
				in_ready = stat.can_emit;
				if (in_valid && stat.can_emit) begin
					cmd.take = 1'b1;
					if (!open_q) begin
						if (stat.in_amp && !stat.in_eot) begin
							open_d = 1'b1;
							cmd.op = hed_pkg::OP_CLEAR;
						end else begin
							cmd.emit = hed_pkg::EM_IN;
							cmd.last = 1'b1;
							cmd.done = stat.in_eot;
						end
					end else if (stat.in_semi) begin
						open_d  = 1'b0;
						state_d = hed_pkg::S_MATCH;
					end else begin
						cmd.op = hed_pkg::OP_APPEND;
						if (stat.cnt_fill) begin
							open_d  = 1'b0;
							state_d = hed_pkg::S_RAMP;
						end else if (stat.in_eot) begin
							open_d  = 1'b0;
							semi_d  = 1'b0;
							state_d = hed_pkg::S_VAMP;
						end
					end
				end
			end
			hed_pkg::S_MATCH: begin
				if (stat.name_hit) begin
					if (stat.can_emit) begin
						cmd.emit = hed_pkg::EM_NAME;
						cmd.last = 1'b1;
						cmd.done = stat.eot;
						cmd.op   = hed_pkg::OP_CLEAR;
						state_d  = hed_pkg::S_IDLE;
					end
				end else if (stat.num_start) begin
					cmd.op  = hed_pkg::OP_PARSE_INIT;
					state_d = hed_pkg::S_PARSE;
				end else begin
					semi_d  = 1'b1;
					state_d = hed_pkg::S_VAMP;
				end
			end
			hed_pkg::S_PARSE: begin
				if (stat.parse_end) begin
					if (stat.code_ok) begin
						cmd.op  = hed_pkg::OP_IDX_CLR;
						state_d = hed_pkg::S_UTF;
					end else begin
						semi_d  = 1'b1;
						state_d = hed_pkg::S_VAMP;
					end
				end else if (stat.digit_bad) begin
					semi_d  = 1'b1;
					state_d = hed_pkg::S_VAMP;
				end else begin
					cmd.op = hed_pkg::OP_PARSE_STEP;
				end
			end
			hed_pkg::S_UTF: begin
				if (stat.can_emit) begin
					cmd.emit = hed_pkg::EM_UTF;
					if (stat.utf_last) begin
						cmd.last = 1'b1;
						cmd.done = stat.eot;
						cmd.op   = hed_pkg::OP_CLEAR;
						state_d  = hed_pkg::S_IDLE;
					end else begin
						cmd.op = hed_pkg::OP_IDX_INC;
					end
				end
			end
			hed_pkg::S_VAMP: begin
				if (stat.can_emit) begin
					cmd.emit = hed_pkg::EM_AMP;
					if (!stat.cnt_zero) begin
						cmd.op  = hed_pkg::OP_IDX_CLR;
						state_d = hed_pkg::S_VBYTES;
					end else if (semi_q) begin
						state_d = hed_pkg::S_VSEMI;
					end else begin
						cmd.last = 1'b1;
						cmd.done = stat.eot;
						cmd.op   = hed_pkg::OP_CLEAR;
						state_d  = hed_pkg::S_IDLE;
					end
				end
			end
			hed_pkg::S_VBYTES: begin
				if (stat.can_emit) begin
					cmd.emit = hed_pkg::EM_BUF;
					if (!stat.buf_last) begin
						cmd.op = hed_pkg::OP_IDX_INC;
					end else if (semi_q) begin
						state_d = hed_pkg::S_VSEMI;
					end else begin
						cmd.last = 1'b1;
						cmd.done = stat.eot;
						cmd.op   = hed_pkg::OP_CLEAR;
						state_d  = hed_pkg::S_IDLE;
					end
				end
			end
			hed_pkg::S_VSEMI: begin
				if (stat.can_emit) begin
					cmd.emit = hed_pkg::EM_SEMI;
					cmd.last = 1'b1;
					cmd.done = stat.eot;
					cmd.op   = hed_pkg::OP_CLEAR;
					state_d  = hed_pkg::S_IDLE;
				end
			end
			hed_pkg::S_RAMP: begin
				if (stat.can_emit) begin
					cmd.emit = hed_pkg::EM_AMP;
					cmd.last = stat.buf0_amp && !stat.eot;
					cmd.op   = hed_pkg::OP_RESCAN_INIT;
					state_d  = hed_pkg::S_RSTEP;
				end
			end
			hed_pkg::S_RSTEP: begin
				cmd.look = 1'b1;
				if (!emit_need || stat.can_emit) begin
					cmd.op    = hed_pkg::OP_RESCAN_STEP;
					cmd.store = open_q;
					if (emit_need) begin
						cmd.emit = hed_pkg::EM_CUR;
						cmd.last = stat.idx_end || (stat.look_amp && !stat.eot);
						cmd.done = stat.idx_end && stat.eot;
					end
					if (!open_q && stat.cur_amp) open_d = 1'b1;
					if (stat.idx_end) begin
						if ((open_q || stat.cur_amp) && stat.eot) begin
							open_d  = 1'b0;
							semi_d  = 1'b0;
							state_d = hed_pkg::S_VAMP;
						end else begin
							state_d = hed_pkg::S_IDLE;
						end
					end
				end
			end
			default: state_d = hed_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== rtl/html_entity_decoder_unit.sv =====
// Streaming HTML entity decoder: one text byte in per beat, zero or more decoded bytes out.
// A plain byte, or a byte that only extends an open entity, is taken straight from the idle state,
// so ordinary text flows at one byte per cycle while the output register has room. On ';' the
// controller resolves the entity: name match, then numeric digits one by one and a closing check,
// then the output bytes (1 to 4 UTF-8 bytes, or '&', the held bytes and ';' when it is emitted
// verbatim). A window overflow writes out the '&' and scans the held bytes again; an end-of-text
// flush writes out '&' and the held bytes. Output bytes leave one per cycle, as out_ready allows,
// from a single output register; the input side is held off while a result waits there unaccepted.
// Depends on hed_pkg, hed_ctrl, hed_datapath.
`timescale 1ns / 1ps

module html_entity_decoder_unit #(
	parameter int ENTITY_WINDOW = hed_pkg::ENTITY_WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hed_pkg::hed_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output hed_pkg::hed_out_t out_data
);

	hed_pkg::hed_cmd_t  cmd;
	hed_pkg::hed_stat_t stat;

	hed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hed_datapath #(
		.ENTITY_WINDOW (ENTITY_WINDOW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/hed_checker.sv =====
// hed_checker: port-level assertions for html_entity_decoder_unit, attached by bind.
// Depends on hed_pkg.
`timescale 1ns / 1ps

module hed_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input hed_pkg::hed_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input hed_pkg::hed_out_t out_data
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// input is only taken when the output register can take a result
	a_in_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input ready while output register is blocked");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.text_done || out_data.run_last))
		else $error("text_done without run_last");

endmodule

bind html_entity_decoder_unit hed_checker u_hed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
